// File: design/rgai_pkg.sv
// ----------------------------------------------------------------------------
// rgai_pkg - shared types and constants of the gyro angle integrator
// Field widths, register codes, controller states and the command bundle
// between the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package rgai_pkg;

  // sample bits that the converter delivers; the input field is 10 bits wide
  localparam int SAMPLE_BITS = 10;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int DT_W     = 16;
  localparam int ANGLE_W  = 64;
  localparam int OFS_W    = 10;
  localparam int REM_W    = 16;
  localparam int DIV_W    = 16;

  // fractional accumulator sum and restoring divider
  localparam int FRAC_W   = 33;
  localparam int CNT_W    = $clog2(FRAC_W);

  // signed rate term and products
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = DIFF_W + DT_W + 1;
  localparam int RPROD_W  = REM_W + DT_W;

  // stream and register port widths
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 64;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // low SAMPLE_BITS bits of the sample take part
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // register index codes (word address)
  typedef enum logic [1:0] {
    REG_ZERO_OFFSET = 2'd0,
    REG_OFFSET_REM  = 2'd1,
    REG_OFFSET_DIV  = 2'd2
  } reg_idx_e;

  // item kind carried in tuser
  typedef enum logic {
    OP_INTEGRATE = 1'b0,
    OP_LOAD      = 1'b1
  } opcode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DTH,
    ST_ACC,
    ST_OUT
  } state_e;

  // calibration registers as seen by the datapath
  typedef struct packed {
    logic [OFS_W-1:0] zero_offset;
    logic [REM_W-1:0] remainder;
    logic [DIV_W-1:0] divisor;
  } cfg_t;

  // datapath commands from the sequencer
  typedef struct packed {
    logic accept;
    logic mul;
    logic sum;
    logic div_step;
    logic dth;
    logic acc;
    logic out_load;
  } cmd_t;

endpackage

`default_nettype wire

// File: design/rate_gyro_angle_integrator_core.sv
// ----------------------------------------------------------------------------
// rate_gyro_angle_integrator_core - rate gyro angle integrator
// Integrates offset-corrected gyro samples times elapsed time into a 64-bit
// angle, with a fractional offset correction kept as a running remainder.
//
//   channel   direction  handshake              contents
//   s_axis    in         tvalid/tready          tuser opcode, tdata sample,
//                                               interval_us, load_angle
//   m_axis    out        tvalid/tready          tdata angle
//   apb       in         psel/penable/pready    zero_offset, remainder, divisor
//
// An integrate item passes from acceptance through multiply, sum, 33 steps of the
// serial restoring divider, correction, update and result load, then returns to idle
// for the next acceptance. A load item goes from acceptance straight to result load.
// Reset clears the angle and the fractional remainder; the divisor resets to 1.
// A stalled result holds the next item at result load; input is accepted only
// between items, while the previous result may still wait for transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module rate_gyro_angle_integrator_core
  import rgai_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // sample[9:0], interval_us[25:10],
                                                     // load_angle[89:26], zero[95:90]
  input  wire logic                   s_axis_tuser,  // opcode[0]
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,  // angle[63:0]
  // register port
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [PDATA_W-1:0]     pwdata,
  output logic      [PDATA_W-1:0]     prdata,
  output logic                        pready
);

  cfg_t cfg;
  cmd_t cmd;

  assign pready = 1'b1;

  // calibration registers
  rgai_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // sequencer
  rgai_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // datapath
  rgai_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .in_data_i  (s_axis_tdata),
    .in_op_i    (s_axis_tuser),
    .out_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: design/rgai_regs.sv
// ----------------------------------------------------------------------------
// rgai_regs - calibration register file
// Register-bus write and read decode for zero offset, offset remainder and
// offset divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rgai_regs
  import rgai_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output cfg_t                    cfg_o
);

  logic [OFS_W-1:0] zero_offset_q;
  logic [REM_W-1:0] remainder_q;
  logic [DIV_W-1:0] divisor_q;
  logic             wr_en;
  reg_idx_e         idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_e'(paddr[3:2]);

  // register writes; the top word address is unmapped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_offset_q <= '0;
      remainder_q   <= '0;
      divisor_q     <= DIV_W'(1);
    end else if (wr_en) begin
      case (idx)
        REG_ZERO_OFFSET: zero_offset_q <= pwdata[OFS_W-1:0];
        REG_OFFSET_REM:  remainder_q   <= pwdata[REM_W-1:0];
        REG_OFFSET_DIV:  divisor_q     <= pwdata[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ZERO_OFFSET: prdata = PDATA_W'(zero_offset_q);
      REG_OFFSET_REM:  prdata = PDATA_W'(remainder_q);
      REG_OFFSET_DIV:  prdata = PDATA_W'(divisor_q);
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = '{zero_offset: zero_offset_q, remainder: remainder_q, divisor: divisor_q};

endmodule

`default_nettype wire

// File: design/rgai_dp.sv
// ----------------------------------------------------------------------------
// rgai_dp - integrator datapath
// Rate product, fractional accumulator with a serial restoring divider,
// angle accumulator and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgai_dp
  import rgai_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  input  wire cfg_t                   cfg_i,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  input  wire logic                   in_op_i,
  output logic      [OUT_TDATA_W-1:0] out_data_o
);

  logic        [SAMPLE_W-1:0] smp_q;
  logic        [DT_W-1:0]     dt_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic        [RPROD_W-1:0]  rprod_q;
  logic        [REM_W-1:0]    frac_q;
  logic        [DIV_W-1:0]    part_q;
  logic        [FRAC_W-1:0]   quo_q;
  logic        [ANGLE_W-1:0]  dth_q;
  logic        [ANGLE_W-1:0]  angle_q;
  logic        [ANGLE_W-1:0]  out_q;

  logic signed [DIFF_W-1:0]   diff;
  logic        [DIV_W-1:0]    div_eff;
  logic        [DIV_W:0]      trial;
  logic        [DIV_W:0]      trial_sub;
  logic                       qbit;

  // offset-corrected sample; a zero divisor acts as one
  assign diff    = $signed({1'b0, smp_q & SAMPLE_MASK}) - $signed({1'b0, cfg_i.zero_offset});
  assign div_eff = (cfg_i.divisor == '0) ? DIV_W'(1) : cfg_i.divisor;

  // one restoring divider step: shift in the next dividend bit and try
  assign trial     = {part_q, quo_q[FRAC_W-1]};
  assign trial_sub = trial - {1'b0, div_eff};
  assign qbit      = (trial >= {1'b0, div_eff});

  // operand capture, products and divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      smp_q <= in_data_i[SAMPLE_W-1:0];
      dt_q  <= in_data_i[SAMPLE_W +: DT_W];
    end
    if (cmd_i.mul) begin
      prod_q  <= PROD_W'(diff * $signed({1'b0, dt_q}));
      rprod_q <= cfg_i.remainder * dt_q;
    end
    if (cmd_i.sum) begin
      quo_q  <= FRAC_W'(frac_q) + FRAC_W'(rprod_q);
      part_q <= '0;
    end else if (cmd_i.div_step) begin
      part_q <= qbit ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q  <= {quo_q[FRAC_W-2:0], qbit};
    end
    if (cmd_i.dth) begin
      dth_q <= ANGLE_W'(prod_q) - ANGLE_W'(quo_q);
    end
    if (cmd_i.out_load) begin
      out_q <= angle_q;
    end
  end

  // accumulator state: fractional remainder and angle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q  <= '0;
      angle_q <= '0;
    end else begin
      if (cmd_i.dth) begin
        frac_q <= part_q;
      end
      if (cmd_i.accept && (opcode_e'(in_op_i) == OP_LOAD)) begin
        angle_q <= in_data_i[SAMPLE_W+DT_W +: ANGLE_W];
      end else if (cmd_i.acc) begin
        angle_q <= angle_q - dth_q;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: design/rgai_ctrl.sv
// ----------------------------------------------------------------------------
// rgai_ctrl - integrator sequencer
// Steps one item through multiply, sum, divide and update (a load item goes straight
// to result load), and owns the input ready and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rgai_ctrl
  import rgai_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_op_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  // result register can take a new value
  assign out_free = !out_valid_q || out_ready_i;

  // state, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (opcode_e'(in_op_i) == OP_LOAD) ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_W'(FRAC_W - 1)) begin
          state_d = ST_DTH;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DTH: begin
        cmd_o.dth = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result valid follows loads and transfers
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before transfer");

  // an accepted item blocks the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready while an item is in flight");

  // divider step count stays within the dividend width
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= CNT_W'(FRAC_W - 1)))
    else $error("divider step counter out of range");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the rate gyro angle integrator
// Drives integrate and load transfers with bursty input and a stalling
// result side, programs the calibration registers over the register port
// between phases, and compares every returned angle against a bit-exact
// software copy of the integrator kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rgai_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 95;

  // angle integrator copy and expected angle store
  class gyro_angle_tracker;
    logic [ANGLE_W-1:0] angle_acc;
    logic [FRAC_W-1:0]  frac_acc;
    logic [OFS_W-1:0]   zero_ofs;
    logic [REM_W-1:0]   ofs_rem;
    logic [DIV_W-1:0]   ofs_div;
    logic [ANGLE_W-1:0] angle_q[$];
    int unsigned        errors;

    function new();
      angle_acc = '0;
      frac_acc  = '0;
      zero_ofs  = '0;
      ofs_rem   = '0;
      ofs_div   = DIV_W'(1);
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_ZERO_OFFSET: zero_ofs = value[OFS_W-1:0];
        REG_OFFSET_REM:  ofs_rem  = value[REM_W-1:0];
        REG_OFFSET_DIV:  ofs_div  = value[DIV_W-1:0];
        default: ;
      endcase
    endfunction

    // advance the integrator by one accepted transfer
    function void note_item(opcode_e op, logic [SAMPLE_W-1:0] smp, logic [DT_W-1:0] dt,
                            logic [ANGLE_W-1:0] load);
      logic signed [ANGLE_W-1:0] diff;
      logic signed [ANGLE_W-1:0] prod;
      logic [DIV_W-1:0]          divisor;
      logic [FRAC_W-1:0]         quot;
      if (op == OP_LOAD) begin
        angle_acc = load;
      end else begin
        diff = $signed({54'd0, smp & SAMPLE_MASK}) - $signed({54'd0, zero_ofs});
        prod = diff * $signed({48'd0, dt});
        frac_acc = frac_acc + {17'd0, ofs_rem} * {17'd0, dt};
        // a zero divisor behaves as one
        divisor = (ofs_div == '0) ? DIV_W'(1) : ofs_div;
        quot = frac_acc / {17'd0, divisor};
        frac_acc = frac_acc % {17'd0, divisor};
        angle_acc = angle_acc - (prod - {31'd0, quot});
      end
      angle_q.push_back(angle_acc);
    endfunction

    function void check_angle(logic [ANGLE_W-1:0] got);
      logic [ANGLE_W-1:0] want;
      if (angle_q.size() == 0) begin
        $display("%0t: unexpected angle transfer, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = angle_q.pop_front();
        if (got !== want) begin
          $display("%0t: angle wrong, expected %h, actual %h", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return angle_q.size();
    endfunction
  endclass

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;  // sample, interval_us, load_angle, zero pad
  logic                   s_axis_tuser = 1'b0;  // opcode
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;  // angle
  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_W-1:0]     paddr   = '0;
  logic [PDATA_W-1:0]     pwdata  = '0;
  wire  [PDATA_W-1:0]     prdata;
  wire                    pready;

  gyro_angle_tracker tracker;

  // sender burst shaping and receiver stall knobs
  int unsigned burst_left = 0;
  int unsigned burst_max  = 1;
  int unsigned gap_max    = 0;
  int unsigned stall_max  = 0;
  int unsigned stall_pct  = 0;
  int unsigned idle_cycles = 0;

  rate_gyro_angle_integrator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side stall pattern
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (stall_max != 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(stall_max, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      tracker.check_angle(m_axis_tdata);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("rate_gyro_angle_integrator_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transfer, with a random gap at the end of each burst
  task automatic send_item(input opcode_e op, input logic [SAMPLE_W-1:0] smp,
                           input logic [DT_W-1:0] dt, input logic [ANGLE_W-1:0] load);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(burst_max, 1);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, load, dt, smp};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_item(op, smp, dt, load);
    burst_left--;
  endtask

  // register write, setup then access
  task automatic write_reg(input reg_idx_e idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, value);
  endtask

  // stop input and wait for every outstanding angle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_calibration(input logic [OFS_W-1:0] zero, input logic [REM_W-1:0] rem,
                                 input logic [DIV_W-1:0] div);
    drain();
    write_reg(REG_ZERO_OFFSET, {22'd0, zero});
    write_reg(REG_OFFSET_REM, {16'd0, rem});
    write_reg(REG_OFFSET_DIV, {16'd0, div});
  endtask

  initial begin
    logic [OFS_W-1:0]    zero;
    logic [REM_W-1:0]    rem;
    logic [DIV_W-1:0]    div;
    logic [SAMPLE_W-1:0] smp;
    logic [DT_W-1:0]     dt;
    logic [ANGLE_W-1:0]  load;
    opcode_e             op;
    int unsigned         pick;

    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset calibration, extremes and wrap in both directions
    send_item(OP_INTEGRATE, 10'd1023, 16'hFFFF, 64'h0123_4567_89AB_CDEF);
    send_item(OP_LOAD, 10'd511, 16'h1234, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_INTEGRATE, 10'd1023, 16'hFFFF, 64'h0);
    send_item(OP_LOAD, 10'd0, 16'h0, 64'h8000_0000_0000_0000);
    send_item(OP_INTEGRATE, 10'd1023, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(OP_INTEGRATE, 10'd0, 16'h0, 64'h5555_5555_5555_5555);
    send_item(OP_LOAD, 10'd1023, 16'hFFFF, 64'h0);

    // zero divisor: whole fractional sum becomes the correction
    set_calibration(10'd1023, 16'hFFFF, 16'd0);
    send_item(OP_INTEGRATE, 10'd0, 16'hFFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_LOAD, 10'd0, 16'h0, 64'h7FFF_FFFF_FFFF_FF00);
    send_item(OP_INTEGRATE, 10'd0, 16'hFFFF, 64'h0);
    send_item(OP_INTEGRATE, 10'd1023, 16'hFFFF, 64'h0);
    send_item(OP_INTEGRATE, 10'd512, 16'h0, 64'hFFFF_FFFF_FFFF_FFFF);

    // remainder above divisor
    set_calibration(10'd512, 16'hFFFF, 16'd1000);
    send_item(OP_INTEGRATE, 10'd512, 16'hFFFF, 64'h0);
    send_item(OP_INTEGRATE, 10'd0, 16'd1, 64'h0);
    send_item(OP_INTEGRATE, 10'd1023, 16'hFFFF, 64'h0);
    send_item(OP_LOAD, 10'd3, 16'd7, 64'hFFFF_FFFF_FFFF_FFFF);

    // largest divisor, slow fractional build-up kept across a load
    set_calibration(10'd0, 16'd1, 16'hFFFF);
    send_item(OP_INTEGRATE, 10'd1, 16'hFFFF, 64'h0);
    send_item(OP_INTEGRATE, 10'd1, 16'hFFFF, 64'h0);
    send_item(OP_LOAD, 10'd0, 16'h0, 64'h0);
    send_item(OP_INTEGRATE, 10'd0, 16'd2, 64'h0);

    // random phases, each with its own calibration and idling mix
    for (int ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(3);
      zero = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 : OFS_W'($urandom);
      pick = $urandom_range(5);
      div  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1 : (pick == 2) ? 16'hFFFF :
             (pick == 3) ? DIV_W'($urandom_range(16, 2)) : DIV_W'($urandom);
      pick = $urandom_range(4);
      rem  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
             (pick == 2 && div > 1) ? REM_W'($urandom_range(div - 1)) : REM_W'($urandom);
      set_calibration(zero, rem, div);

      if (ph == 0) begin
        gap_max = 0; burst_max = 1; stall_max = 0; stall_pct = 0;
      end else begin
        gap_max   = $urandom_range(40);
        burst_max = $urandom_range(20, 1);
        stall_max = $urandom_range(60);
        stall_pct = $urandom_range(60, 5);
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(99) < 15) ? OP_LOAD : OP_INTEGRATE;
        pick = $urandom_range(9);
        smp = (pick == 0) ? 10'd0 : (pick == 1) ? 10'd1023 :
              (pick == 2) ? zero + SAMPLE_W'($urandom_range(4)) - SAMPLE_W'(2) :
              SAMPLE_W'($urandom);
        pick = $urandom_range(9);
        dt  = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
              (pick == 2) ? DT_W'($urandom_range(8)) : DT_W'($urandom);
        pick = $urandom_range(7);
        // loads near the ends of the range make the angle wrap
        load = (pick == 0) ? {1'b0, 63'h7FFF_FFFF_FFFF_FFFF} - ANGLE_W'($urandom_range(1 << 20)) :
               (pick == 1) ? {1'b1, 63'd0} + ANGLE_W'($urandom_range(1 << 20)) :
               {$urandom, $urandom};
        send_item(op, smp, dt, load);
      end
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("rate_gyro_angle_integrator_core: match");
    end else begin
      $display("rate_gyro_angle_integrator_core: mismatch");
    end
    $finish;
  end

endmodule
